// ----- sv/sbsu_pkg.sv -----
package sbsu_pkg;

  localparam int DEF_MAX_COARSE_ROWS = 256;
  localparam int DEF_MAX_FINE_ROWS   = 256;
  localparam int DEF_MAX_NONZEROS    = 4096;
  localparam int DEF_MAX_BLOCK       = 3;

  localparam int VAL_W   = 64;
  localparam int RS_W    = 13;
  localparam int COL_W   = 8;
  localparam int NROWS_W = 9;
  localparam int BS_W    = 2;
  localparam int SQ_W    = 4;
  localparam int CIDX_W  = 2;

  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_RUN   = 2'd2;

  localparam logic [3:0] SEL_CC_RS  = 4'd0;
  localparam logic [3:0] SEL_CC_COL = 4'd1;
  localparam logic [3:0] SEL_CC_VAL = 4'd2;
  localparam logic [3:0] SEL_CF_RS  = 4'd3;
  localparam logic [3:0] SEL_CF_COL = 4'd4;
  localparam logic [3:0] SEL_CF_VAL = 4'd5;
  localparam logic [3:0] SEL_FC_RS  = 4'd6;
  localparam logic [3:0] SEL_FC_COL = 4'd7;
  localparam logic [3:0] SEL_FC_VAL = 4'd8;
  localparam logic [3:0] SEL_INV    = 4'd9;

  localparam logic [CIDX_W-1:0] CFG_NUM_ROWS   = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_BLOCK_SIZE = 2'd1;

  typedef struct packed {
    logic [1:0]              func;
    logic [3:0]              table_sel;
    logic [15:0]             addr;
    logic [RS_W-1:0]         index_word;
    logic signed [VAL_W-1:0] value_word;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic                    done_res;
    logic                    saturated;
  } out_t;

  typedef enum logic [4:0] {
    S_IDLE, S_READ, S_EMIT, S_START, S_ROW, S_ROW_LO, S_ROW_HI,
    S_P, S_P_COL, S_P_LO, S_P_HI, S_Q, S_Q_KEY, S_BS, S_BS_CMP,
    S_PB_RD, S_PB_MUL, S_PB_ACC, S_UP_RD, S_UP_MUL, S_UP_ACC, S_UP_WB
  } sbsu_state_e;

  typedef enum logic [1:0] {
    MUL_IDLE, MUL_PP, MUL_NEG, MUL_RND
  } sbsu_mul_state_e;

endpackage

// ----- sv/sbsu_mul.sv -----
module sbsu_mul (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [sbsu_pkg::VAL_W-1:0]       a_i,
  input  logic [sbsu_pkg::VAL_W-1:0]       b_i,
  output logic                             done_o,
  output logic [sbsu_pkg::VAL_W-1:0]       res_o,
  output logic                             sat_o
);
  import sbsu_pkg::*;

  sbsu_mul_state_e st_q, st_d;
  logic [63:0]  ma_q, ma_d, mb_q, mb_d;
  logic         neg_q, neg_d;
  logic [127:0] acc_q, acc_d;
  logic [1:0]   idx_q, idx_d;
  logic [63:0]  res_q, res_d;
  logic         sat_q, sat_d;
  logic         done_q, done_d;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [127:0] rnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= MUL_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ma_q  <= ma_d;
    mb_q  <= mb_d;
    neg_q <= neg_d;
    acc_q <= acc_d;
    idx_q <= idx_d;
    res_q <= res_d;
    sat_q <= sat_d;
  end

  always_comb begin
    st_d   = st_q;
    ma_d   = ma_q;
    mb_d   = mb_q;
    neg_d  = neg_q;
    acc_d  = acc_q;
    idx_d  = idx_q;
    res_d  = res_q;
    sat_d  = sat_q;
    done_d = 1'b0;
    pp     = 64'(ma_q[31:0]) * 64'(mb_q[31:0]);
    case (idx_q)
      2'd0:    pp = 64'(ma_q[31:0])  * 64'(mb_q[31:0]);
      2'd1:    pp = 64'(ma_q[63:32]) * 64'(mb_q[31:0]);
      2'd2:    pp = 64'(ma_q[31:0])  * 64'(mb_q[63:32]);
      default: pp = 64'(ma_q[63:32]) * 64'(mb_q[63:32]);
    endcase
    case (idx_q)
      2'd0:    pp_sh = 128'(pp);
      2'd3:    pp_sh = 128'(pp) << 64;
      default: pp_sh = 128'(pp) << 32;
    endcase
    rnd = acc_q + (128'(1) << 39);
    unique case (st_q)
      MUL_IDLE: begin
        if (start_i) begin
          ma_d  = a_i[63] ? (64'd0 - a_i) : a_i;
          mb_d  = b_i[63] ? (64'd0 - b_i) : b_i;
          neg_d = a_i[63] ^ b_i[63];
          acc_d = '0;
          idx_d = 2'd0;
          st_d  = MUL_PP;
        end
      end
      MUL_PP: begin
        acc_d = acc_q + pp_sh;
        idx_d = idx_q + 2'd1;
        if (idx_q == 2'd3) begin
          st_d = MUL_NEG;
        end
      end
      MUL_NEG: begin
        if (neg_q) begin
          acc_d = 128'd0 - acc_q;
        end
        st_d = MUL_RND;
      end
      MUL_RND: begin
        if (rnd[127:103] == {25{rnd[127]}}) begin
          res_d = rnd[103:40];
          sat_d = 1'b0;
        end else begin
          res_d = rnd[127] ? VAL_MIN : VAL_MAX;
          sat_d = 1'b1;
        end
        done_d = 1'b1;
        st_d   = MUL_IDLE;
      end
      default: st_d = MUL_IDLE;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;
  assign sat_o  = sat_q;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("multiplier done held");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> st_q == MUL_IDLE) else $error("done outside idle");
  a_pp_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == MUL_NEG |-> $past(st_q) == MUL_PP && idx_q == 2'd0)
    else $error("partial products skipped");

endmodule

// ----- sv/sparse_block_schur_update.sv -----
// Sparse block Schur-complement update: A_CC -= A_CF * inv(A_FF) * A_FC inside
// the existing A_CC pattern, signed Q24.40 arithmetic with saturation.
// Input channel (in_valid_i/in_ready_o/in_data_i): one transaction per item.
// A write item stores one table word; a read item returns a coarse value; a run
// item performs the whole update and returns done with the saturation flag.
// Output channel (out_valid_o/out_ready_i/out_data_o): one result per item.
// Configuration channel (cfg_valid_i/cfg_ready_o), always ready: the user must
// write num_rows and block_size only while no item is in flight. Not enforced.
// A run walks every A_CF entry, binary-searches each A_FC column in the A_CC
// row, and spends on each scalar product one table-read state, one start state,
// then the shared 64x64 multiplier over four 32x32 partial products, plus one
// write-back state per block element of each hit. The input is not ready while
// an item works.
// A finished result waits in the output register while the next item is
// taken; a stalled receiver holds it and blocks only the following result.
// Reset clears control state and sets num_rows 0, block_size 1; the tables
// are undefined until written.
module sparse_block_schur_update #(
  parameter int MAX_COARSE_ROWS = sbsu_pkg::DEF_MAX_COARSE_ROWS,
  parameter int MAX_FINE_ROWS   = sbsu_pkg::DEF_MAX_FINE_ROWS,
  parameter int MAX_NONZEROS    = sbsu_pkg::DEF_MAX_NONZEROS,
  parameter int MAX_BLOCK       = sbsu_pkg::DEF_MAX_BLOCK
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  sbsu_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sbsu_pkg::out_t                out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sbsu_pkg::CIDX_W-1:0]   cfg_index_i,
  input  logic [sbsu_pkg::NROWS_W-1:0]  cfg_data_i
);
  import sbsu_pkg::*;

  localparam int BLK_SQ    = MAX_BLOCK * MAX_BLOCK;
  localparam int CRS_DEPTH = MAX_COARSE_ROWS + 1;
  localparam int FRS_DEPTH = MAX_FINE_ROWS + 1;
  localparam int VAL_DEPTH = MAX_NONZEROS * BLK_SQ;
  localparam int INV_DEPTH = MAX_FINE_ROWS * BLK_SQ;
  localparam int CRW  = $clog2(CRS_DEPTH);
  localparam int FRSW = $clog2(FRS_DEPTH);
  localparam int NZW  = $clog2(MAX_NONZEROS + 1);
  localparam int CIW  = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
  localparam int VAW  = (VAL_DEPTH > 1) ? $clog2(VAL_DEPTH) : 1;
  localparam int IVW  = (INV_DEPTH > 1) ? $clog2(INV_DEPTH) : 1;
  localparam int PBW  = (BLK_SQ > 1) ? $clog2(BLK_SQ) : 1;

  function automatic logic [NZW-1:0] clamp_nz(logic [RS_W-1:0] v);
    return (32'(v) > MAX_NONZEROS) ? NZW'(MAX_NONZEROS) : NZW'(v);
  endfunction

  function automatic logic [VAL_W:0] add_sat(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
    logic [VAL_W-1:0] s;
    s = a + b;
    if (a[VAL_W-1] == b[VAL_W-1] && s[VAL_W-1] != a[VAL_W-1]) begin
      return {1'b1, a[VAL_W-1] ? VAL_MIN : VAL_MAX};
    end
    return {1'b0, s};
  endfunction

  function automatic logic [VAL_W:0] sub_sat(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
    logic [VAL_W-1:0] s;
    s = a - b;
    if (a[VAL_W-1] != b[VAL_W-1] && s[VAL_W-1] != a[VAL_W-1]) begin
      return {1'b1, a[VAL_W-1] ? VAL_MIN : VAL_MAX};
    end
    return {1'b0, s};
  endfunction

  logic [RS_W-1:0]  cc_row_start [CRS_DEPTH];
  logic [COL_W-1:0] cc_columns   [MAX_NONZEROS];
  logic [VAL_W-1:0] cc_values    [VAL_DEPTH];
  logic [RS_W-1:0]  cf_row_start [CRS_DEPTH];
  logic [COL_W-1:0] cf_columns   [MAX_NONZEROS];
  logic [VAL_W-1:0] cf_values    [VAL_DEPTH];
  logic [VAL_W-1:0] inverse_fine_blocks [INV_DEPTH];
  logic [RS_W-1:0]  fc_row_start [FRS_DEPTH];
  logic [COL_W-1:0] fc_columns   [MAX_NONZEROS];
  logic [VAL_W-1:0] fc_values    [VAL_DEPTH];

  logic [RS_W-1:0]  cc_rs_rd_q, cf_rs_rd_q, fc_rs_rd_q;
  logic [COL_W-1:0] cc_col_rd_q, cf_col_rd_q, fc_col_rd_q;
  logic [VAL_W-1:0] cc_val_rd_q, cf_val_rd_q, fc_val_rd_q, inv_rd_q;

  logic [CRW-1:0]   rs_ra;
  logic [FRSW-1:0]  fc_rs_ra;
  logic [CIW-1:0]   cc_col_ra, cf_col_ra, fc_col_ra;
  logic [VAW-1:0]   cc_val_ra, cf_val_ra, fc_val_ra;
  logic [IVW-1:0]   inv_ra;
  logic             cc_val_we;
  logic [VAW-1:0]   cc_val_wa;
  logic [VAL_W-1:0] cc_val_wd;

  logic             wr_acc;
  logic             we_cc_rs, we_cc_col, we_cc_val, we_cf_rs, we_cf_col, we_cf_val;
  logic             we_fc_rs, we_fc_col, we_fc_val, we_inv;

  sbsu_state_e      st_q, st_d;
  out_t             out_q, out_d, resp_q, resp_d;
  logic             out_valid_q, out_valid_d;
  logic             rd_ok_q, rd_ok_d;
  logic [NROWS_W-1:0] num_rows_q;
  logic [BS_W-1:0]  block_size_q;
  logic [CRW-1:0]   i_q, i_d, rows_q, rows_d;
  logic [BS_W-1:0]  bs_q, bs_d;
  logic [SQ_W-1:0]  sq_q, sq_d;
  logic [NZW-1:0]   cs_q, cs_d, clen_q, clen_d, p_q, p_d, fe_q, fe_d;
  logic [NZW-1:0]   q_q, q_d, qe_q, qe_d, lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [COL_W-1:0] colf_q, colf_d, key_q, key_d;
  logic [CIW-1:0]   pos_q, pos_d;
  logic             have_q, have_d, sat_q, sat_d;
  logic [BS_W-1:0]  c_q, c_d, r_q, r_d, k_q, k_d;
  logic [VAL_W-1:0] s_q, s_d;
  logic [VAL_W-1:0] pb_q [BLK_SQ];
  logic             pb_we;
  logic [PBW-1:0]   pb_wa;

  logic             mul_start;
  logic [VAL_W-1:0] mul_a, mul_b, mul_res;
  logic             mul_done, mul_sat;
  logic [VAL_W:0]   sum_ov, sub_ov;
  logic [NZW-1:0]   ce, mid_w;
  logic [BS_W-1:0]  last;
  logic [NZW-1:0]   crows;
  logic [PBW-1:0]   pb_ra;
  logic [VAW-1:0]   cc_d_addr;

  sbsu_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res),
    .sat_o   (mul_sat)
  );

  assign in_ready_o  = (st_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign wr_acc    = in_valid_i && in_ready_o && in_data_i.func == FUNC_WRITE;
  assign we_cc_rs  = wr_acc && in_data_i.table_sel == SEL_CC_RS  && 32'(in_data_i.addr) < CRS_DEPTH;
  assign we_cc_col = wr_acc && in_data_i.table_sel == SEL_CC_COL
                     && 32'(in_data_i.addr) < MAX_NONZEROS;
  assign we_cc_val = wr_acc && in_data_i.table_sel == SEL_CC_VAL && 32'(in_data_i.addr) < VAL_DEPTH;
  assign we_cf_rs  = wr_acc && in_data_i.table_sel == SEL_CF_RS  && 32'(in_data_i.addr) < CRS_DEPTH;
  assign we_cf_col = wr_acc && in_data_i.table_sel == SEL_CF_COL
                     && 32'(in_data_i.addr) < MAX_NONZEROS;
  assign we_cf_val = wr_acc && in_data_i.table_sel == SEL_CF_VAL && 32'(in_data_i.addr) < VAL_DEPTH;
  assign we_fc_rs  = wr_acc && in_data_i.table_sel == SEL_FC_RS  && 32'(in_data_i.addr) < FRS_DEPTH;
  assign we_fc_col = wr_acc && in_data_i.table_sel == SEL_FC_COL
                     && 32'(in_data_i.addr) < MAX_NONZEROS;
  assign we_fc_val = wr_acc && in_data_i.table_sel == SEL_FC_VAL && 32'(in_data_i.addr) < VAL_DEPTH;
  assign we_inv    = wr_acc && in_data_i.table_sel == SEL_INV    && 32'(in_data_i.addr) < INV_DEPTH;

  always_ff @(posedge clk_i) begin
    if (we_cc_rs) cc_row_start[CRW'(in_data_i.addr)] <= in_data_i.index_word;
    cc_rs_rd_q <= cc_row_start[rs_ra];
  end

  always_ff @(posedge clk_i) begin
    if (we_cf_rs) cf_row_start[CRW'(in_data_i.addr)] <= in_data_i.index_word;
    cf_rs_rd_q <= cf_row_start[rs_ra];
  end

  always_ff @(posedge clk_i) begin
    if (we_fc_rs) fc_row_start[FRSW'(in_data_i.addr)] <= in_data_i.index_word;
    fc_rs_rd_q <= fc_row_start[fc_rs_ra];
  end

  always_ff @(posedge clk_i) begin
    if (we_cc_col) cc_columns[CIW'(in_data_i.addr)] <= in_data_i.index_word[COL_W-1:0];
    cc_col_rd_q <= cc_columns[cc_col_ra];
  end

  always_ff @(posedge clk_i) begin
    if (we_cf_col) cf_columns[CIW'(in_data_i.addr)] <= in_data_i.index_word[COL_W-1:0];
    cf_col_rd_q <= cf_columns[cf_col_ra];
  end

  always_ff @(posedge clk_i) begin
    if (we_fc_col) fc_columns[CIW'(in_data_i.addr)] <= in_data_i.index_word[COL_W-1:0];
    fc_col_rd_q <= fc_columns[fc_col_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cc_val_we) cc_values[cc_val_wa] <= cc_val_wd;
    cc_val_rd_q <= cc_values[cc_val_ra];
  end

  always_ff @(posedge clk_i) begin
    if (we_cf_val) cf_values[VAW'(in_data_i.addr)] <= in_data_i.value_word;
    cf_val_rd_q <= cf_values[cf_val_ra];
  end

  always_ff @(posedge clk_i) begin
    if (we_fc_val) fc_values[VAW'(in_data_i.addr)] <= in_data_i.value_word;
    fc_val_rd_q <= fc_values[fc_val_ra];
  end

  always_ff @(posedge clk_i) begin
    if (we_inv) inverse_fine_blocks[IVW'(in_data_i.addr)] <= in_data_i.value_word;
    inv_rd_q <= inverse_fine_blocks[inv_ra];
  end

  always_ff @(posedge clk_i) begin
    if (pb_we) pb_q[pb_wa] <= sum_ov[VAL_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q   <= '0;
      block_size_q <= BS_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_NUM_ROWS:   num_rows_q   <= cfg_data_i;
        CFG_BLOCK_SIZE: block_size_q <= cfg_data_i[BS_W-1:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    resp_q  <= resp_d;
    rd_ok_q <= rd_ok_d;
    i_q     <= i_d;
    rows_q  <= rows_d;
    bs_q    <= bs_d;
    sq_q    <= sq_d;
    cs_q    <= cs_d;
    clen_q  <= clen_d;
    p_q     <= p_d;
    fe_q    <= fe_d;
    q_q     <= q_d;
    qe_q    <= qe_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    colf_q  <= colf_d;
    key_q   <= key_d;
    pos_q   <= pos_d;
    have_q  <= have_d;
    sat_q   <= sat_d;
    c_q     <= c_d;
    r_q     <= r_d;
    k_q     <= k_d;
    s_q     <= s_d;
  end

  assign last      = bs_q - BS_W'(1);
  assign crows     = NZW'(32'(cs_q) + 32'(mid_q));
  assign pb_ra     = PBW'(32'(k_q) * 32'(bs_q) + 32'(r_q));
  assign cc_d_addr = VAW'(32'(pos_q) * 32'(sq_q) + 32'(c_q) * 32'(bs_q) + 32'(r_q));
  assign sum_ov    = add_sat(s_q, mul_res);
  assign sub_ov    = sub_sat(cc_val_rd_q, s_q);
  assign ce        = clamp_nz(cc_rs_rd_q);
  assign mid_w     = lo_q + ((hi_q - lo_q) >> 1);

  always_comb begin
    st_d        = st_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    resp_d      = resp_q;
    rd_ok_d     = rd_ok_q;
    i_d = i_q;   rows_d = rows_q; bs_d = bs_q;   sq_d = sq_q;
    cs_d = cs_q; clen_d = clen_q; p_d = p_q;     fe_d = fe_q;
    q_d = q_q;   qe_d = qe_q;     lo_d = lo_q;   hi_d = hi_q;
    mid_d = mid_q; colf_d = colf_q; key_d = key_q; pos_d = pos_q;
    have_d = have_q; sat_d = sat_q;
    c_d = c_q;   r_d = r_q;       k_d = k_q;     s_d = s_q;
    rs_ra      = CRW'(i_q);
    fc_rs_ra   = FRSW'(colf_q);
    cc_col_ra  = CIW'(crows);
    cf_col_ra  = CIW'(p_q);
    fc_col_ra  = CIW'(q_q);
    cc_val_ra  = VAW'(in_data_i.addr);
    cf_val_ra  = VAW'(32'(p_q) * 32'(sq_q) + 32'(k_q) * 32'(bs_q) + 32'(r_q));
    fc_val_ra  = VAW'(32'(q_q) * 32'(sq_q) + 32'(c_q) * 32'(bs_q) + 32'(k_q));
    inv_ra     = IVW'(32'(colf_q) * 32'(sq_q) + 32'(c_q) * 32'(bs_q) + 32'(k_q));
    cc_val_we  = we_cc_val;
    cc_val_wa  = VAW'(in_data_i.addr);
    cc_val_wd  = in_data_i.value_word;
    pb_we      = 1'b0;
    pb_wa      = PBW'(32'(c_q) * 32'(bs_q) + 32'(r_q));
    mul_start  = 1'b0;
    mul_a      = cf_val_rd_q;
    mul_b      = inv_rd_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          resp_d  = '0;
          rd_ok_d = 32'(in_data_i.addr) < VAL_DEPTH;
          unique case (in_data_i.func)
            FUNC_READ: st_d = S_READ;
            FUNC_RUN:  st_d = S_START;
            default:   st_d = S_EMIT;
          endcase
        end
      end
      S_READ: begin
        resp_d.read_value = rd_ok_q ? cc_val_rd_q : '0;
        st_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = resp_q;
          out_valid_d = 1'b1;
          st_d        = S_IDLE;
        end
      end
      S_START: begin
        sat_d  = 1'b0;
        bs_d   = block_size_q;
        sq_d   = SQ_W'(block_size_q) * SQ_W'(block_size_q);
        rows_d = (32'(num_rows_q) > MAX_COARSE_ROWS) ? CRW'(MAX_COARSE_ROWS)
                                                     : CRW'(num_rows_q);
        i_d    = '0;
        resp_d.done_res = 1'b1;
        if (block_size_q == '0 || 32'(block_size_q) > MAX_BLOCK || rows_d == '0) begin
          st_d = S_EMIT;
        end else begin
          st_d = S_ROW;
        end
      end
      S_ROW: begin
        rs_ra = CRW'(i_q);
        st_d  = S_ROW_LO;
      end
      S_ROW_LO: begin
        cs_d  = clamp_nz(cc_rs_rd_q);
        p_d   = clamp_nz(cf_rs_rd_q);
        rs_ra = i_q + CRW'(1);
        st_d  = S_ROW_HI;
      end
      S_ROW_HI: begin
        clen_d = (ce > cs_q) ? (ce - cs_q) : '0;
        fe_d   = clamp_nz(cf_rs_rd_q);
        st_d   = S_P;
      end
      S_P: begin
        if (p_q >= fe_q) begin
          i_d = i_q + CRW'(1);
          if (i_d == rows_q) begin
            resp_d.saturated = sat_q;
            st_d = S_EMIT;
          end else begin
            st_d = S_ROW;
          end
        end else begin
          st_d = S_P_COL;
        end
      end
      S_P_COL: begin
        colf_d = cf_col_rd_q;
        if (32'(cf_col_rd_q) >= MAX_FINE_ROWS) begin
          p_d  = p_q + NZW'(1);
          st_d = S_P;
        end else begin
          fc_rs_ra = FRSW'(cf_col_rd_q);
          st_d     = S_P_LO;
        end
      end
      S_P_LO: begin
        q_d      = clamp_nz(fc_rs_rd_q);
        fc_rs_ra = FRSW'(32'(colf_q) + 1);
        st_d     = S_P_HI;
      end
      S_P_HI: begin
        qe_d   = clamp_nz(fc_rs_rd_q);
        have_d = 1'b0;
        st_d   = S_Q;
      end
      S_Q: begin
        if (q_q >= qe_q) begin
          p_d  = p_q + NZW'(1);
          st_d = S_P;
        end else begin
          st_d = S_Q_KEY;
        end
      end
      S_Q_KEY: begin
        key_d = fc_col_rd_q;
        lo_d  = '0;
        hi_d  = clen_q;
        st_d  = S_BS;
      end
      S_BS: begin
        if (lo_q >= hi_q) begin
          q_d  = q_q + NZW'(1);
          st_d = S_Q;
        end else begin
          mid_d     = mid_w;
          cc_col_ra = CIW'(32'(cs_q) + 32'(mid_w));
          st_d      = S_BS_CMP;
        end
      end
      S_BS_CMP: begin
        if (cc_col_rd_q == key_q) begin
          pos_d = CIW'(crows);
          c_d = '0; r_d = '0; k_d = '0; s_d = '0;
          st_d  = have_q ? S_UP_RD : S_PB_RD;
        end else if (key_q < cc_col_rd_q) begin
          hi_d = mid_q;
          st_d = S_BS;
        end else begin
          lo_d = mid_q + NZW'(1);
          st_d = S_BS;
        end
      end
      S_PB_RD: begin
        st_d = S_PB_MUL;
      end
      S_PB_MUL: begin
        mul_start = 1'b1;
        st_d      = S_PB_ACC;
      end
      S_PB_ACC: begin
        if (mul_done) begin
          sat_d = sat_q | mul_sat | sum_ov[VAL_W];
          st_d  = S_PB_RD;
          if (k_q == last) begin
            pb_we = 1'b1;
            s_d   = '0;
            k_d   = '0;
            if (r_q == last) begin
              r_d = '0;
              if (c_q == last) begin
                c_d    = '0;
                have_d = 1'b1;
                st_d   = S_UP_RD;
              end else begin
                c_d = c_q + BS_W'(1);
              end
            end else begin
              r_d = r_q + BS_W'(1);
            end
          end else begin
            k_d = k_q + BS_W'(1);
            s_d = sum_ov[VAL_W-1:0];
          end
        end
      end
      S_UP_RD: begin
        st_d = S_UP_MUL;
      end
      S_UP_MUL: begin
        mul_start = 1'b1;
        mul_a     = pb_q[pb_ra];
        mul_b     = fc_val_rd_q;
        st_d      = S_UP_ACC;
      end
      S_UP_ACC: begin
        if (mul_done) begin
          sat_d = sat_q | mul_sat | sum_ov[VAL_W];
          s_d   = sum_ov[VAL_W-1:0];
          if (k_q == last) begin
            cc_val_ra = cc_d_addr;
            st_d      = S_UP_WB;
          end else begin
            k_d  = k_q + BS_W'(1);
            st_d = S_UP_RD;
          end
        end
      end
      S_UP_WB: begin
        cc_val_we = 1'b1;
        cc_val_wa = cc_d_addr;
        cc_val_wd = sub_ov[VAL_W-1:0];
        sat_d     = sat_q | sub_ov[VAL_W];
        s_d       = '0;
        k_d       = '0;
        st_d      = S_UP_RD;
        if (r_q == last) begin
          r_d = '0;
          if (c_q == last) begin
            c_d  = '0;
            q_d  = q_q + NZW'(1);
            st_d = S_Q;
          end else begin
            c_d = c_q + BS_W'(1);
          end
        end else begin
          r_d = r_q + BS_W'(1);
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  a_sat_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturated |-> out_data_o.done_res)
    else $error("saturation reported outside a run");
  a_run_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |-> out_data_o.read_value == '0)
    else $error("run result carries a value");
  a_mul_own: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> st_q == S_PB_ACC || st_q == S_UP_ACC)
    else $error("multiplier result unclaimed");
  a_wb_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_UP_WB |-> $past(st_q) == S_UP_ACC)
    else $error("write-back without accumulation");

endmodule
